FILE: rtl/s_expression_tokenizer_top_macros.svh
// Assertion macros for the S-expression tokenizer.
`ifndef S_EXPRESSION_TOKENIZER_TOP_MACROS_SVH
`define S_EXPRESSION_TOKENIZER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clk outside reset.
`define SXT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sxt assertion failed");

// Next-cycle implication, checked on every rising clk outside reset.
`define SXT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sxt assertion failed");

`else

`define SXT_ASSERT_IMPL(label, ante, cons)
`define SXT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/sxt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sxt_pkg;

	localparam int MAX_TEXT_LEN = 65536;
	localparam int POS_MAX_INT  = ((MAX_TEXT_LEN - 1) < 65535) ? (MAX_TEXT_LEN - 1) : 65535;
	localparam logic [15:0] POS_MAX = 16'(POS_MAX_INT);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_OPEN   = 8'h28;
	localparam logic [7:0] CH_CLOSE  = 8'h29;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [3:0] {
		K_QUOTE  = 4'd0,
		K_DOT    = 4'd1,
		K_OPEN   = 4'd2,
		K_CLOSE  = 4'd3,
		K_STRING = 4'd4,
		K_CHAR   = 4'd5,
		K_NUMBER = 4'd6,
		K_SYMBOL = 4'd7,
		K_END    = 4'd8,
		K_ERROR  = 4'd9
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} lex_out_t;

endpackage

`default_nettype wire

FILE: rtl/sxt_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module sxt_fifo import sxt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [1:0]       push_cnt,
	input  wire res_t             din0,
	input  wire res_t             din1,
	input  wire logic             pop,
	output      res_t             head,
	output      logic [LVL_W-1:0] level
);

	res_t               mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [LVL_W-1:0]   level_q;
	logic [FIFO_AW-1:0] wr_ptr_1;

	assign wr_ptr_1 = wr_ptr_q + FIFO_AW'(1);
	assign head     = mem[rd_ptr_q];
	assign level    = level_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem[wr_ptr_q] <= din0;
		end
		if (push_cnt == 2'd2) begin
			mem[wr_ptr_1] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			level_q <= level_q + LVL_W'(push_cnt) - LVL_W'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sxt_lexer.sv
`timescale 1ns / 1ps
`default_nettype none

module sxt_lexer import sxt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] char_code,
	output      lex_out_t   res
);

	typedef enum logic [2:0] {
		M_IDLE,
		M_STRING,
		M_CHAR,
		M_NUMBER,
		M_SYMBOL
	} mode_t;

	mode_t       mode_q;
	logic [15:0] pos_q;
	logic [15:0] begin_q;
	logic        bs_q;

	logic        is_sp;
	logic        is_sep;
	logic        st_emit;
	kind_t       st_kind;
	logic [15:0] st_len;
	mode_t       st_mode;
	logic        st_begin;
	logic        st_over;

	mode_t       nmode;
	logic [15:0] nbegin;
	logic        over;
	logic [15:0] diff;
	logic [16:0] str_len;
	logic [15:0] str_len_sat;
	logic [1:0]  cnt;
	res_t        r0;
	res_t        r1;

	function automatic res_t mk_res(kind_t k, logic [15:0] s, logic [15:0] l);
		res_t r;
		r.kind   = k;
		r.start  = s;
		r.length = l;
		r.last   = 1'b0;
		return r;
	endfunction

	assign is_sp  = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
	assign is_sep = is_sp || (char_code == CH_NUL) || (char_code == CH_QUOTE) ||
		(char_code == CH_DQUOTE) || (char_code == CH_OPEN) || (char_code == CH_CLOSE);

	// token start on a byte seen between tokens
	always_comb begin
		st_emit  = 1'b0;
		st_kind  = K_END;
		st_len   = 16'd0;
		st_mode  = M_IDLE;
		st_begin = 1'b0;
		st_over  = 1'b0;
		if (!is_sp) begin
			unique case (char_code)
				CH_NUL: begin
					st_emit = 1'b1;
					st_kind = K_END;
					st_over = 1'b1;
				end
				CH_QUOTE: begin
					st_emit = 1'b1;
					st_kind = K_QUOTE;
					st_len  = 16'd1;
				end
				CH_DOT: begin
					st_emit = 1'b1;
					st_kind = K_DOT;
					st_len  = 16'd1;
				end
				CH_OPEN: begin
					st_emit = 1'b1;
					st_kind = K_OPEN;
					st_len  = 16'd1;
				end
				CH_CLOSE: begin
					st_emit = 1'b1;
					st_kind = K_CLOSE;
					st_len  = 16'd1;
				end
				CH_DQUOTE: begin
					st_mode  = M_STRING;
					st_begin = 1'b1;
				end
				CH_QMARK: begin
					st_mode  = M_CHAR;
					st_begin = 1'b1;
				end
				default: begin
					st_mode  = ((char_code >= CH_ZERO) && (char_code <= CH_NINE)) ?
						M_NUMBER : M_SYMBOL;
					st_begin = 1'b1;
				end
			endcase
		end
	end

	assign diff        = pos_q - begin_q;
	assign str_len     = {1'b0, diff} + 17'd1;
	assign str_len_sat = str_len[16] ? 16'hFFFF : str_len[15:0];

	always_comb begin
		nmode  = mode_q;
		nbegin = begin_q;
		over   = 1'b0;
		cnt    = 2'd0;
		r0     = '0;
		r1     = '0;
		unique case (mode_q)
			M_STRING: begin
				if (char_code == CH_NUL) begin
					r0   = mk_res(K_ERROR, begin_q, diff);
					cnt  = 2'd1;
					over = 1'b1;
				end else if ((char_code == CH_DQUOTE) && !bs_q) begin
					r0    = mk_res(K_STRING, begin_q, str_len_sat);
					cnt   = 2'd1;
					nmode = M_IDLE;
				end
			end
			M_CHAR: begin
				if (char_code == CH_NUL) begin
					r0   = mk_res(K_ERROR, begin_q, 16'd1);
					over = 1'b1;
				end else begin
					r0 = mk_res(K_CHAR, pos_q, 16'd1);
				end
				cnt   = 2'd1;
				nmode = M_IDLE;
			end
			M_NUMBER, M_SYMBOL: begin
				if (is_sep) begin
					r0    = mk_res((mode_q == M_NUMBER) ? K_NUMBER : K_SYMBOL, begin_q, diff);
					nmode = st_mode;
					over  = st_over;
					if (st_begin) begin
						nbegin = pos_q;
					end
					if (st_emit) begin
						r1  = mk_res(st_kind, pos_q, st_len);
						cnt = 2'd2;
					end else begin
						cnt = 2'd1;
					end
				end
			end
			default: begin
				nmode = st_mode;
				over  = st_over;
				if (st_begin) begin
					nbegin = pos_q;
				end
				if (st_emit) begin
					r0  = mk_res(st_kind, pos_q, st_len);
					cnt = 2'd1;
				end
			end
		endcase
		if (cnt == 2'd1) begin
			r0.last = 1'b1;
		end
		if (cnt == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	assign res.count = advance ? cnt : 2'd0;
	assign res.r0    = r0;
	assign res.r1    = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			bs_q    <= 1'b0;
		end else if (advance) begin
			if (over) begin
				mode_q  <= M_IDLE;
				pos_q   <= '0;
				begin_q <= '0;
				bs_q    <= 1'b0;
			end else begin
				mode_q  <= nmode;
				begin_q <= nbegin;
				bs_q    <= (char_code == CH_BSLASH);
				if (pos_q < POS_MAX) begin
					pos_q <= pos_q + 16'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/s_expression_tokenizer_top.sv
// S-expression tokenizer.
// Input channel: char_valid / char_stall / char_code, one text byte per beat;
// byte 0 ends the text and the next byte starts a new text at offset 0.
// Output channel: token_valid / token_stall with token_kind, token_start,
// token_length and last_of_run; a byte causes zero, one or two tokens, and
// last_of_run marks the final token of that byte.
// Path: a taken byte waits in the input register, is lexed combinationally,
// and its tokens are written into the queue, which drives the output.
// Throughput: one byte per cycle while the queue has room, set by the lexer
// step behind the input register; tokens leave one per cycle unless stalled
// via a four-entry queue, so two-token bytes are paced at one token per cycle.
// Stall: when the receiver holds token_stall the queue fills; the input
// register keeps its byte and char_stall rises once fewer than two queue
// entries are free. No token is dropped.
// Reset: arst_n clears the lexer to idle between tokens at offset 0 and
// empties the input register and the queue.
`timescale 1ns / 1ps
`default_nettype none
`include "s_expression_tokenizer_top_macros.svh"

module s_expression_tokenizer_top import sxt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        char_valid,
	output      logic        char_stall,
	input  wire logic [7:0]  char_code,
	output      logic        token_valid,
	input  wire logic        token_stall,
	output      logic [3:0]  token_kind,
	output      logic [15:0] token_start,
	output      logic [15:0] token_length,
	output      logic        last_of_run
);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             room;
	logic             advance;
	logic             accept;
	logic             pop;
	lex_out_t         lex;
	res_t             head;
	logic [LVL_W-1:0] level;

	assign room       = level <= LVL_W'(FIFO_DEPTH - 2);
	assign advance    = valid_s1 && room;
	assign char_stall = valid_s1 && !room;
	assign accept     = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_code;
		end
	end

	sxt_lexer u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.char_code (char_s1),
		.res       (lex)
	);

	sxt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (lex.count),
		.din0     (lex.r0),
		.din1     (lex.r1),
		.pop      (pop),
		.head     (head),
		.level    (level)
	);

	assign token_valid  = level != '0;
	assign pop          = token_valid && !token_stall;
	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign last_of_run  = head.last;

	`SXT_ASSERT_IMPL(a_level_bound, 1'b1, level <= LVL_W'(FIFO_DEPTH))
	`SXT_ASSERT_IMPL(a_pair_last, lex.count == 2'd2, !lex.r0.last && lex.r1.last)
	`SXT_ASSERT_NEXT(a_push_visible, lex.count != 2'd0, token_valid)

endmodule

`default_nettype wire
